@@ hw/rtl/prgl_pkg.sv @@
// ----------------------------------------------------------------------------
// prgl_pkg: shared types and constants for the price range gain/loss block
// Field widths, status and operation codes, controller/datapath interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prgl_pkg;

  localparam int unsigned DefaultDepth = 1024;

  localparam int unsigned PriceW = 31;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned StatW  = 2;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [StatW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatW-1:0] STATUS_FULL      = 2'd1;
  localparam logic [StatW-1:0] STATUS_BAD_RANGE = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // item taken this cycle
    logic read;      // read next price of the range
    logic load_out;  // copy result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic range_ok;  // query range at the input is valid
    logic last_read; // read index has reached the range end
  } stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/prgl_ctrl.sv @@
// ----------------------------------------------------------------------------
// prgl_ctrl: sequencing state machine
// Accepts items, steps the range scan and hands results to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prgl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          operation_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire prgl_pkg::stat_t stat_i,
  output prgl_pkg::cmd_t     cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d         = state_q;
    out_valid_d     = out_valid_q;
    cmd_o.accept    = accept;
    cmd_o.read      = 1'b0;
    cmd_o.load_out  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == prgl_pkg::OP_QUERY && stat_i.range_ok) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.read = 1'b1;
        if (stat_i.last_read) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last price is folded in at this edge
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/prgl_dp.sv @@
// ----------------------------------------------------------------------------
// prgl_dp: price store and scan datapath
// Holds the price memory and entry count, tracks running min/max and the
// best rise and worst fall, and owns the output payload register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prgl_dp #(
  parameter int unsigned DEPTH = prgl_pkg::DefaultDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire prgl_pkg::cmd_t              cmd_i,
  output prgl_pkg::stat_t                  stat_o,
  input  wire logic                        operation_i,
  input  wire logic [prgl_pkg::PriceW-1:0] price_i,
  input  wire logic [prgl_pkg::IdxW-1:0]   range_start_i,
  input  wire logic [prgl_pkg::IdxW-1:0]   range_end_i,
  output logic [prgl_pkg::StatW-1:0]       status_o,
  output logic                             gain_found_o,
  output logic [prgl_pkg::PriceW-1:0]      gain_o,
  output logic [prgl_pkg::IdxW-1:0]        gain_buy_index_o,
  output logic [prgl_pkg::IdxW-1:0]        gain_sell_index_o,
  output logic                             loss_found_o,
  output logic [prgl_pkg::PriceW-1:0]      loss_o,
  output logic [prgl_pkg::IdxW-1:0]        loss_peak_index_o,
  output logic [prgl_pkg::IdxW-1:0]        loss_trough_index_o
);

  localparam int unsigned PW = prgl_pkg::PriceW;
  localparam int unsigned IW = prgl_pkg::IdxW;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = (CW > IW) ? CW : IW;

  logic [PW-1:0] mem [DEPTH];

  logic [CW-1:0] count_q;
  logic          not_full;

  logic [IW-1:0] idx_q, end_q, rd_idx_q;
  logic          rd_valid_q, rd_first_q;
  logic [PW-1:0] rdata_q;

  logic [PW-1:0] min_q, max_q, gain_q, loss_q;
  logic [IW-1:0] min_i_q, max_i_q;
  logic [IW-1:0] buy_q, sell_q, peak_q, trough_q;
  logic [prgl_pkg::StatW-1:0] status_q;

  logic [PW-1:0] rise, fall;

  assign not_full = (count_q < CW'(DEPTH));

  assign stat_o.range_ok  = (EW'(range_end_i) < EW'(count_q)) &&
                            (range_start_i <= range_end_i);
  assign stat_o.last_read = (idx_q == end_q);

  assign rise = rdata_q - min_q;
  assign fall = max_q - rdata_q;

  // store write on push, registered read during scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && operation_i == prgl_pkg::OP_PUSH && not_full) begin
      mem[AW'(count_q)] <= price_i;
    end
    if (cmd_i.read) begin
      rdata_q <= mem[AW'(idx_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.read;
      if (cmd_i.accept && operation_i == prgl_pkg::OP_PUSH && not_full) begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q      <= range_start_i;
      end_q      <= range_end_i;
      rd_first_q <= 1'b1;
      gain_q     <= '0;
      buy_q      <= '0;
      sell_q     <= '0;
      loss_q     <= '0;
      peak_q     <= '0;
      trough_q   <= '0;
      if (operation_i == prgl_pkg::OP_PUSH) begin
        status_q <= not_full ? prgl_pkg::STATUS_OK : prgl_pkg::STATUS_FULL;
      end else begin
        status_q <= stat_o.range_ok ? prgl_pkg::STATUS_OK : prgl_pkg::STATUS_BAD_RANGE;
      end
    end else begin
      if (cmd_i.read) begin
        idx_q    <= idx_q + IW'(1);
        rd_idx_q <= idx_q;
      end
      if (rd_valid_q) begin
        if (rd_first_q) begin
          // first price of the range seeds the running min and max
          rd_first_q <= 1'b0;
          min_q      <= rdata_q;
          max_q      <= rdata_q;
          min_i_q    <= rd_idx_q;
          max_i_q    <= rd_idx_q;
        end else begin
          // ties keep the earlier minimum/maximum and the earlier best pair
          if (rdata_q < min_q) begin
            min_q   <= rdata_q;
            min_i_q <= rd_idx_q;
          end else if (rise > gain_q) begin
            gain_q <= rise;
            buy_q  <= min_i_q;
            sell_q <= rd_idx_q;
          end
          if (rdata_q > max_q) begin
            max_q   <= rdata_q;
            max_i_q <= rd_idx_q;
          end else if (fall > loss_q) begin
            loss_q   <= fall;
            peak_q   <= max_i_q;
            trough_q <= rd_idx_q;
          end
        end
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o            <= status_q;
      gain_found_o        <= (gain_q != '0);
      gain_o              <= gain_q;
      gain_buy_index_o    <= buy_q;
      gain_sell_index_o   <= sell_q;
      loss_found_o        <= (loss_q != '0);
      loss_o              <= loss_q;
      loss_peak_index_o   <= peak_q;
      loss_trough_index_o <= trough_q;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/price_range_max_gain_loss.sv @@
// ----------------------------------------------------------------------------
// price_range_max_gain_loss: price store with range best-rise/worst-fall query
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i/in_ready_o   | operation, price, range bounds
//   out     | output    | out_valid_o/out_ready_i | status, gain and loss fields
//
// A push or a bad-range query goes from accept straight to the finish state.
// A query over indices start..end passes the scan, drain and finish states,
// reading one price per cycle in the scan from the price memory's single read port.
// Reset clears the entry count and control; the price memory is not cleared.
// One item is in work at a time; a new item is accepted while the previous
// result waits in the output register, and a stalled output holds the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module price_range_max_gain_loss #(
  parameter int unsigned DEPTH = prgl_pkg::DefaultDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        operation_i,
  input  wire logic [prgl_pkg::PriceW-1:0] price_i,
  input  wire logic [prgl_pkg::IdxW-1:0]   range_start_i,
  input  wire logic [prgl_pkg::IdxW-1:0]   range_end_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [prgl_pkg::StatW-1:0]       status_o,
  output logic                             gain_found_o,
  output logic [prgl_pkg::PriceW-1:0]      gain_o,
  output logic [prgl_pkg::IdxW-1:0]        gain_buy_index_o,
  output logic [prgl_pkg::IdxW-1:0]        gain_sell_index_o,
  output logic                             loss_found_o,
  output logic [prgl_pkg::PriceW-1:0]      loss_o,
  output logic [prgl_pkg::IdxW-1:0]        loss_peak_index_o,
  output logic [prgl_pkg::IdxW-1:0]        loss_trough_index_o
);

  prgl_pkg::cmd_t  cmd;
  prgl_pkg::stat_t stat;

  prgl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  prgl_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .operation_i         (operation_i),
    .price_i             (price_i),
    .range_start_i       (range_start_i),
    .range_end_i         (range_end_i),
    .status_o            (status_o),
    .gain_found_o        (gain_found_o),
    .gain_o              (gain_o),
    .gain_buy_index_o    (gain_buy_index_o),
    .gain_sell_index_o   (gain_sell_index_o),
    .loss_found_o        (loss_found_o),
    .loss_o              (loss_o),
    .loss_peak_index_o   (loss_peak_index_o),
    .loss_trough_index_o (loss_trough_index_o)
  );

endmodule

`default_nettype wire
